// ----- sv/scl_pkg.sv -----
// scl_pkg: shared constants, operation and status codes, and the node store command type
// for the sorted cursor list block; used by scl_node_mem, scl_ctrl and the top level.
// depends on nothing.
package scl_pkg;

  localparam int unsigned DEF_NODES      = 16;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned VALUE_W  = 32;

  localparam logic [FUNC_W-1:0] FN_INS_HEAD = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_TAIL = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_SORT = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_HEAD = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL_TAIL = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DUMP     = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic rd_en;
    logic wr_next_en;
    logic wr_val_en;
  } mem_cmd_t;

endpackage

// ----- sv/sorted_cursor_list_with_free_list.sv -----
// Sorted cursor list with free list, top level: stream ports, sequencer and node store.
// An insert first takes a node from the free list. A head insert, or any insert into an
// empty list, then links it in at once; a tail or sorted insert walks the list first. A
// refused insert, or a delete or dump on an empty list, goes straight to its result.
// Unused codes are taken without a result. Walks visit up to NODES nodes, one per cycle
// while a dump is not held by back-pressure, because the node store has a single read
// port. Back-pressure on the result side stalls the block while a result waits. One
// operation is in flight at a time. A result waits in the output register while the next
// item is taken. Values are kept as DATA_WIDTH-bit two's complement numbers, and the
// sorted insert compares them signed.
// depends on scl_pkg, scl_node_mem and scl_ctrl.
module sorted_cursor_list_with_free_list
  import scl_pkg::*;
#(
  parameter int unsigned NODES      = DEF_NODES,
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [VALUE_W-1:0]   in_tdata,   // data
  input  logic [FUNC_W-1:0]    in_tuser,   // func
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [VALUE_W-1:0]   out_tdata,  // value
  output logic [STATUS_W-1:0]  out_tuser,  // status
  output logic                 out_tlast
);

  localparam int unsigned AW = $clog2(NODES);
  localparam int unsigned IW = $clog2(NODES + 1);

  mem_cmd_t              mem_cmd;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [IW-1:0]         wr_next;
  logic [DATA_WIDTH-1:0] wr_val;
  logic [IW-1:0]         rd_next;
  logic [DATA_WIDTH-1:0] rd_val;

  scl_ctrl #(
    .NODES      (NODES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_data    (in_tdata),
    .in_func    (in_tuser),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_value  (out_tdata),
    .out_last   (out_tlast),
    .mem_cmd    (mem_cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .wr_next    (wr_next),
    .wr_val     (wr_val),
    .rd_next    (rd_next),
    .rd_val     (rd_val)
  );

  scl_node_mem #(
    .NODES      (NODES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_node_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (mem_cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_next (wr_next),
    .wr_val  (wr_val),
    .rd_next (rd_next),
    .rd_val  (rd_val)
  );

endmodule

// ----- sv/scl_node_mem.sv -----
// scl_node_mem: node store with a link memory and a value memory, one read and one write
// port each, registered read data; link entries read as i+1 until first written.
// depends on scl_pkg.
module scl_node_mem
  import scl_pkg::*;
#(
  parameter int unsigned NODES      = DEF_NODES,
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mem_cmd_t                          cmd,
  input  logic [$clog2(NODES)-1:0]          rd_addr,
  input  logic [$clog2(NODES)-1:0]          wr_addr,
  input  logic [$clog2(NODES+1)-1:0]        wr_next,
  input  logic [DATA_WIDTH-1:0]             wr_val,
  output logic [$clog2(NODES+1)-1:0]        rd_next,
  output logic [DATA_WIDTH-1:0]             rd_val
);

  localparam int unsigned AW = $clog2(NODES);
  localparam int unsigned IW = $clog2(NODES + 1);

  logic [IW-1:0]         next_mem [NODES];
  logic [DATA_WIDTH-1:0] val_mem  [NODES];
  logic [NODES-1:0]      vld_r;

  logic [IW-1:0]         rd_next_q;
  logic [DATA_WIDTH-1:0] rd_val_q;
  logic [AW-1:0]         rd_addr_q;
  logic                  rd_vld_q;

  // written flags for the link memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.wr_next_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_next_en) begin
      next_mem[wr_addr] <= wr_next;
    end
    if (cmd.wr_val_en) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (cmd.rd_en) begin
      rd_next_q <= next_mem[rd_addr];
      rd_val_q  <= val_mem[rd_addr];
      rd_vld_q  <= vld_r[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  assign rd_next = rd_vld_q ? rd_next_q : (IW'(rd_addr_q) + IW'(1));
  assign rd_val  = rd_val_q;

endmodule

// ----- sv/scl_ctrl.sv -----
// scl_ctrl: operation sequencer, list and free list head registers, and result register
// for the sorted cursor list block; drives the node store with at most one read and one write per cycle.
// depends on scl_pkg.
module scl_ctrl
  import scl_pkg::*;
#(
  parameter int unsigned NODES      = DEF_NODES,
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [VALUE_W-1:0]                in_data,
  input  logic [FUNC_W-1:0]                 in_func,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [STATUS_W-1:0]               out_status,
  output logic [VALUE_W-1:0]                out_value,
  output logic                              out_last,
  output mem_cmd_t                          mem_cmd,
  output logic [$clog2(NODES)-1:0]          rd_addr,
  output logic [$clog2(NODES)-1:0]          wr_addr,
  output logic [$clog2(NODES+1)-1:0]        wr_next,
  output logic [DATA_WIDTH-1:0]             wr_val,
  input  logic [$clog2(NODES+1)-1:0]        rd_next,
  input  logic [DATA_WIDTH-1:0]             rd_val
);

  localparam int unsigned AW = $clog2(NODES);
  localparam int unsigned IW = $clog2(NODES + 1);
  localparam logic [IW-1:0] NIL = IW'(NODES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TAKE  = 4'd1;
  localparam logic [3:0] S_WALK  = 4'd2;
  localparam logic [3:0] S_LINK  = 4'd3;
  localparam logic [3:0] S_LINK2 = 4'd4;
  localparam logic [3:0] S_DELH  = 4'd5;
  localparam logic [3:0] S_DTAIL = 4'd6;
  localparam logic [3:0] S_FREE  = 4'd7;
  localparam logic [3:0] S_DUMP  = 4'd8;
  localparam logic [3:0] S_RESP  = 4'd9;

  logic [3:0]            state_r, state_nxt;
  logic [IW-1:0]         list_head_r, list_head_nxt;
  logic [IW-1:0]         free_head_r, free_head_nxt;
  logic [FUNC_W-1:0]     func_r, func_nxt;
  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic [IW-1:0]         new_r, new_nxt;
  logic [IW-1:0]         cur_r, cur_nxt;
  logic [IW-1:0]         prev_r, prev_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [VALUE_W-1:0]    res_value_r, res_value_nxt;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [VALUE_W-1:0]    out_value_r;
  logic                  out_last_r;

  logic                  out_free;
  logic                  accept;
  logic                  go_on;
  logic                  emit;
  logic [STATUS_W-1:0]   emit_status;
  logic [VALUE_W-1:0]    emit_value;
  logic                  emit_last;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign go_on    = (func_r == FN_INS_TAIL) || ($signed(rd_val) < $signed(data_r));

  always_comb begin
    state_nxt     = state_r;
    list_head_nxt = list_head_r;
    free_head_nxt = free_head_r;
    func_nxt      = func_r;
    data_nxt      = data_r;
    new_nxt       = new_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    status_nxt    = status_r;
    res_value_nxt = res_value_r;
    mem_cmd       = '0;
    rd_addr       = cur_r[AW-1:0];
    wr_addr       = new_r[AW-1:0];
    wr_next       = NIL;
    wr_val        = data_r;
    emit          = 1'b0;
    emit_status   = status_r;
    emit_value    = res_value_r;
    emit_last     = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt      = in_func;
          data_nxt      = DATA_WIDTH'(in_data);
          status_nxt    = ST_OK;
          res_value_nxt = '0;
          if (in_func == FN_INS_HEAD || in_func == FN_INS_TAIL ||
              in_func == FN_INS_SORT) begin
            if (free_head_r == NIL) begin
              status_nxt = ST_FULL;
              state_nxt  = S_RESP;
            end else begin
              new_nxt        = free_head_r;
              mem_cmd.rd_en  = 1'b1;
              rd_addr        = free_head_r[AW-1:0];
              state_nxt      = S_TAKE;
            end
          end else if (in_func == FN_DEL_HEAD || in_func == FN_DEL_TAIL ||
                       in_func == FN_DUMP) begin
            if (list_head_r == NIL) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_RESP;
            end else begin
              cur_nxt       = list_head_r;
              prev_nxt      = NIL;
              mem_cmd.rd_en = 1'b1;
              rd_addr       = list_head_r[AW-1:0];
              if (in_func == FN_DEL_HEAD) begin
                state_nxt = S_DELH;
              end else if (in_func == FN_DEL_TAIL) begin
                state_nxt = S_DTAIL;
              end else begin
                state_nxt = S_DUMP;
              end
            end
          end
        end
      end
      S_TAKE: begin
        // unlink the new node from the free list, store its value, and link it in or start the walk
        free_head_nxt     = rd_next;
        mem_cmd.wr_val_en = 1'b1;
        if (func_r == FN_INS_HEAD || list_head_r == NIL) begin
          mem_cmd.wr_next_en = 1'b1;
          wr_next            = list_head_r;
          list_head_nxt      = new_r;
          state_nxt          = S_RESP;
        end else begin
          cur_nxt       = list_head_r;
          prev_nxt      = NIL;
          mem_cmd.rd_en = 1'b1;
          rd_addr       = list_head_r[AW-1:0];
          state_nxt     = S_WALK;
        end
      end
      S_WALK: begin
        if (go_on) begin
          prev_nxt = cur_r;
          cur_nxt  = rd_next;
          if (rd_next != NIL) begin
            mem_cmd.rd_en = 1'b1;
            rd_addr       = rd_next[AW-1:0];
          end else begin
            state_nxt = S_LINK;
          end
        end else begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        mem_cmd.wr_next_en = 1'b1;
        wr_next            = cur_r;
        if (prev_r == NIL) begin
          list_head_nxt = new_r;
          state_nxt     = S_RESP;
        end else begin
          state_nxt = S_LINK2;
        end
      end
      S_LINK2: begin
        mem_cmd.wr_next_en = 1'b1;
        wr_addr            = prev_r[AW-1:0];
        wr_next            = new_r;
        state_nxt          = S_RESP;
      end
      S_DELH: begin
        list_head_nxt      = rd_next;
        res_value_nxt      = VALUE_W'(rd_val);
        mem_cmd.wr_next_en = 1'b1;
        wr_addr            = cur_r[AW-1:0];
        wr_next            = free_head_r;
        free_head_nxt      = cur_r;
        state_nxt          = S_RESP;
      end
      S_DTAIL: begin
        if (rd_next != NIL) begin
          prev_nxt      = cur_r;
          cur_nxt       = rd_next;
          mem_cmd.rd_en = 1'b1;
          rd_addr       = rd_next[AW-1:0];
        end else begin
          res_value_nxt      = VALUE_W'(rd_val);
          mem_cmd.wr_next_en = 1'b1;
          if (prev_r == NIL) begin
            list_head_nxt = NIL;
            wr_addr       = cur_r[AW-1:0];
            wr_next       = free_head_r;
            free_head_nxt = cur_r;
            state_nxt     = S_RESP;
          end else begin
            wr_addr   = prev_r[AW-1:0];
            wr_next   = NIL;
            state_nxt = S_FREE;
          end
        end
      end
      S_FREE: begin
        mem_cmd.wr_next_en = 1'b1;
        wr_addr            = cur_r[AW-1:0];
        wr_next            = free_head_r;
        free_head_nxt      = cur_r;
        state_nxt          = S_RESP;
      end
      S_DUMP: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = ST_OK;
          emit_value  = VALUE_W'(rd_val);
          emit_last   = (rd_next == NIL);
          if (rd_next != NIL) begin
            cur_nxt       = rd_next;
            mem_cmd.rd_en = 1'b1;
            rd_addr       = rd_next[AW-1:0];
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      list_head_r <= NIL;
      free_head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      list_head_r <= list_head_nxt;
      free_head_r <= free_head_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    data_r      <= data_nxt;
    new_r       <= new_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    status_r    <= status_nxt;
    res_value_r <= res_value_nxt;
    if (emit) begin
      out_status_r <= emit_status;
      out_value_r  <= emit_value;
      out_last_r   <= emit_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

`ifndef SYNTHESIS
  a_no_link_collision: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_cmd.rd_en && mem_cmd.wr_next_en && rd_addr == wr_addr))
    else $error("link memory read and write hit the same entry");

  a_heads_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    (list_head_r != free_head_r) || (list_head_r == NIL))
    else $error("list head and free head point at the same node");

  a_heads_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (list_head_r <= NIL) && (free_head_r <= NIL))
    else $error("head pointer out of range");

  a_dump_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP && !out_free) |=> (state_r == S_DUMP) && $stable(cur_r))
    else $error("dump walk moved while the result register was full");
`endif

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench for the sorted cursor list block, with a scoreboard class
// that mirrors the node store, free list and list, and a plain task that drives the input stream port.
// depends on scl_pkg and sorted_cursor_list_with_free_list.
module tb_top
  import scl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = DEF_NODES;
  localparam int NIL   = NODES;

  // codes the block leaves unused
  localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
    logic                last;
  } reply_t;

  class list_scoreboard;
    logic signed [VALUE_W-1:0] val_mem [NODES];
    int     link_mem [NODES];
    int     head_idx;
    int     free_idx;
    int     occupancy;
    reply_t replies_due [$];
    int     errors;
    int     ops_seen;
    int     beats_seen;
    int     full_seen;
    int     empty_seen;

    function new();
      for (int i = 0; i < NODES; i++) begin
        val_mem[i]  = '0;
        link_mem[i] = i + 1;
      end
      head_idx   = NIL;
      free_idx   = 0;
      occupancy  = 0;
      errors     = 0;
      ops_seen   = 0;
      beats_seen = 0;
      full_seen  = 0;
      empty_seen = 0;
    endfunction

    function void push_reply(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] value,
                             logic last);
      reply_t r;
      r.status = status;
      r.value  = value;
      r.last   = last;
      replies_due.push_back(r);
    endfunction

    // works out the reply beats of one accepted operation and updates the shadow list
    function void apply_op(logic [FUNC_W-1:0] func, logic signed [VALUE_W-1:0] data);
      int n;
      int cur;
      int prev;
      int k;
      if (func == FN_SPARE_A || func == FN_SPARE_B) return;
      ops_seen++;
      if (func == FN_INS_HEAD || func == FN_INS_TAIL || func == FN_INS_SORT) begin
        n = free_idx;
        if (n >= NODES) begin
          full_seen++;
          push_reply(ST_FULL, '0, 1'b1);
          return;
        end
        free_idx   = link_mem[n];
        val_mem[n] = data;
        prev = NIL;
        cur  = head_idx;
        if (func == FN_INS_TAIL) begin
          for (int s = 0; s < NODES; s++) begin
            if (cur >= NODES) break;
            prev = cur;
            cur  = link_mem[cur];
          end
          cur = NIL;
        end else if (func == FN_INS_SORT) begin
          for (int s = 0; s < NODES; s++) begin
            if (cur >= NODES) break;
            if (!(val_mem[cur] < data)) break;
            prev = cur;
            cur  = link_mem[cur];
          end
        end
        link_mem[n] = cur;
        if (prev < NODES) link_mem[prev] = n;
        else head_idx = n;
        occupancy++;
        push_reply(ST_OK, '0, 1'b1);
        return;
      end
      if (head_idx >= NODES) begin
        empty_seen++;
        push_reply(ST_EMPTY, '0, 1'b1);
        return;
      end
      case (func)
        FN_DEL_HEAD: begin
          n = head_idx;
          head_idx = link_mem[n];
          push_reply(ST_OK, val_mem[n], 1'b1);
          link_mem[n] = free_idx;
          free_idx    = n;
          occupancy--;
        end
        FN_DEL_TAIL: begin
          prev = NIL;
          cur  = head_idx;
          for (int s = 0; s < NODES; s++) begin
            if (link_mem[cur] >= NODES) break;
            prev = cur;
            cur  = link_mem[cur];
          end
          if (prev < NODES) link_mem[prev] = NIL;
          else head_idx = NIL;
          push_reply(ST_OK, val_mem[cur], 1'b1);
          link_mem[cur] = free_idx;
          free_idx      = cur;
          occupancy--;
        end
        default: begin
          k   = 0;
          cur = head_idx;
          while (cur < NODES && k < NODES) begin
            n = link_mem[cur];
            push_reply(ST_OK, val_mem[cur], (n >= NODES) || (k + 1 >= NODES));
            k++;
            cur = n;
          end
        end
      endcase
    endfunction

    function void check_reply(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] value,
                              logic last);
      reply_t r;
      beats_seen++;
      if (replies_due.size() == 0) begin
        $error("reply beat with none expected: status %0d value %h last %0d",
               status, value, last);
        errors++;
        return;
      end
      r = replies_due.pop_front();
      if (status !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, status);
        errors++;
      end
      if (value !== r.value) begin
        $error("value: expected %h, got %h", r.value, value);
        errors++;
      end
      if (last !== r.last) begin
        $error("last: expected %0d, got %0d", r.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [VALUE_W-1:0]  in_tdata;   // data
  logic [FUNC_W-1:0]   in_tuser;   // func
  logic                out_tvalid;
  logic                out_tready;
  logic [VALUE_W-1:0]  out_tdata;  // value
  logic [STATUS_W-1:0] out_tuser;  // status
  logic                out_tlast;

  list_scoreboard sb;
  bit gaps_on;
  bit stalls_on;

  sorted_cursor_list_with_free_list u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $error("run timed out");
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_reply(out_tuser, out_tdata, out_tlast);
  end

  // result side back-pressure in bursts
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_op(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] data);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.apply_op(func, data);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        v = $urandom_range(0, 20);
        v = v - 32'd10;
      end
      4: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [FUNC_W-1:0] pick_insert();
    case ($urandom_range(0, 2))
      0: return FN_INS_HEAD;
      1: return FN_INS_TAIL;
      default: return FN_INS_SORT;
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] pick_delete();
    if ($urandom_range(0, 1) == 0) return FN_DEL_HEAD;
    return FN_DEL_TAIL;
  endfunction

  initial begin
    int  sent;
    int  roll;
    bit  filling;
    logic [FUNC_W-1:0] func;
    sb = new();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    rst_n     <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty list, unused codes, signed extremes and ties
    send_op(FN_DUMP, $urandom);
    send_op(FN_DEL_HEAD, $urandom);
    send_op(FN_DEL_TAIL, $urandom);
    send_op(FN_SPARE_A, $urandom);
    send_op(FN_SPARE_B, $urandom);
    send_op(FN_INS_SORT, 32'h0000_0000);
    send_op(FN_INS_SORT, 32'h7fff_ffff);
    send_op(FN_INS_SORT, 32'h8000_0000);
    send_op(FN_INS_SORT, 32'hffff_ffff);
    send_op(FN_INS_SORT, 32'h0000_0000);
    send_op(FN_INS_SORT, 32'h7fff_ffff);
    send_op(FN_INS_HEAD, 32'h1234_5678);
    send_op(FN_INS_TAIL, 32'h8000_0001);
    send_op(FN_DUMP, $urandom);
    send_op(FN_DEL_HEAD, $urandom);
    send_op(FN_DEL_TAIL, $urandom);
    // fill the pool, then push against it
    while (sb.occupancy < NODES) send_op(FN_INS_SORT, pick_value());
    send_op(FN_INS_HEAD, $urandom);
    send_op(FN_INS_TAIL, $urandom);
    send_op(FN_INS_SORT, $urandom);
    send_op(FN_DUMP, $urandom);

    sent    = 0;
    filling = 1'b0;
    while (sent < 400) begin
      if (sent == 320) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      if (sb.occupancy == NODES && $urandom_range(0, 2) == 0) filling = 1'b0;
      if (sb.occupancy == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        func = ($urandom_range(0, 1) == 0) ? FN_SPARE_A : FN_SPARE_B;
        send_op(func, $urandom);
      end else begin
        if (roll < 13) func = FN_DUMP;
        else if (roll < 73) func = filling ? pick_insert() : pick_delete();
        else func = filling ? pick_delete() : pick_insert();
        send_op(func, pick_value());
        sent++;
      end
    end
    in_tvalid <= 1'b0;

    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d list operations and %0d reply beats", sb.ops_seen, sb.beats_seen);
    $display("including %0d full-pool refusals and %0d empty-list refusals",
             sb.full_seen, sb.empty_seen);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/scl_pkg.sv
sv/scl_node_mem.sv
sv/scl_ctrl.sv
sv/sorted_cursor_list_with_free_list.sv
tb/tb_top.sv
